// ===== src/itoa_pkg.sv =====
package itoa_pkg;

  // field widths
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned NIB_W    = 4;

  // digit counts and the packed digit register
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = VAL_W / NIB_W;
  localparam int unsigned DIG_W      = DEC_DIGITS * NIB_W;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned CNT_W      = 6;

  // kind codes
  localparam logic [KIND_W-1:0] KIND_UDEC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SDEC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX  = 2'd2;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  // 'a' minus ten, so a nibble of ten or more maps straight to its letter
  localparam logic [CHAR_W-1:0] CHAR_A_OFS = 7'h57;

  // load request from the top level to the character sequencer
  typedef struct packed {
    logic             load;
    logic             neg;
    logic             hex;
    logic [DIG_W-1:0] digits;
  } load_t;

endpackage

// ===== src/itoa_dabble.sv =====
module itoa_dabble (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [itoa_pkg::VAL_W-1:0]     mag_i,
  output logic                           done_o,
  output logic [itoa_pkg::DIG_W-1:0]     bcd_o
);

  logic [itoa_pkg::VAL_W-1:0] bin_q, bin_d;
  logic [itoa_pkg::DIG_W-1:0] bcd_q, bcd_d;
  logic [itoa_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic [itoa_pkg::DIG_W-1:0] adj;

  // add 3 to every bcd digit of five or more, digits are independent
  always_comb begin
    for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
      if (bcd_q[i*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] >= 4'd5) begin
        adj[i*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] =
          bcd_q[i*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] + 4'd3;
      end else begin
        adj[i*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] =
          bcd_q[i*itoa_pkg::NIB_W +: itoa_pkg::NIB_W];
      end
    end
  end

  // one binary bit shifted into the bcd register per cycle
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = itoa_pkg::CNT_W'(itoa_pkg::VAL_W);
    end else if (cnt_q != '0) begin
      bin_d  = {bin_q[itoa_pkg::VAL_W-2:0], 1'b0};
      bcd_d  = {adj[itoa_pkg::DIG_W-2:0], bin_q[itoa_pkg::VAL_W-1]};
      cnt_d  = cnt_q - itoa_pkg::CNT_W'(1);
      done_d = (cnt_q == itoa_pkg::CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== src/itoa_emit.sv =====
module itoa_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  itoa_pkg::load_t                 ld_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]     char_code_o,
  output logic                            last_o
);

  logic                          busy_q, busy_d;
  logic                          minus_q, minus_d;
  logic                          skip_q, skip_d;
  logic [itoa_pkg::DIG_W-1:0]    dig_q, dig_d;
  logic [itoa_pkg::REM_W-1:0]    rem_q, rem_d;
  logic                          ovld_q, ovld_d;
  logic [itoa_pkg::CHAR_W-1:0]   char_q, char_d;
  logic                          last_q, last_d;
  logic [itoa_pkg::NIB_W-1:0]    top_nib;
  logic [itoa_pkg::CHAR_W-1:0]   nib_char;
  logic                          send_free;

  assign top_nib   = dig_q[itoa_pkg::DIG_W-1 -: itoa_pkg::NIB_W];
  assign send_free = !ovld_q || !out_stall_i;

  // nibble to ascii digit or lower-case letter
  always_comb begin
    if (top_nib < 4'd10) begin
      nib_char = itoa_pkg::CHAR_ZERO + {3'b000, top_nib};
    end else begin
      nib_char = itoa_pkg::CHAR_A_OFS + {3'b000, top_nib};
    end
  end

  // strip leading zeros one nibble per cycle and send any minus, then send one char per digit
  always_comb begin
    busy_d  = busy_q;
    minus_d = minus_q;
    skip_d  = skip_q;
    dig_d   = dig_q;
    rem_d   = rem_q;
    ovld_d  = send_free ? 1'b0 : ovld_q;
    char_d  = char_q;
    last_d  = last_q;
    if (ld_i.load) begin
      busy_d  = 1'b1;
      minus_d = ld_i.neg;
      skip_d  = 1'b1;
      dig_d   = ld_i.digits;
      rem_d   = ld_i.hex ? itoa_pkg::REM_W'(itoa_pkg::HEX_DIGITS)
                         : itoa_pkg::REM_W'(itoa_pkg::DEC_DIGITS);
    end else if (busy_q) begin
      if (skip_q) begin
        if (top_nib == '0 && rem_q > itoa_pkg::REM_W'(1)) begin
          dig_d = {dig_q[itoa_pkg::DIG_W-itoa_pkg::NIB_W-1:0], {itoa_pkg::NIB_W{1'b0}}};
          rem_d = rem_q - itoa_pkg::REM_W'(1);
        end else begin
          skip_d = 1'b0;
        end
      end
      if (send_free) begin
        if (minus_q) begin
          ovld_d  = 1'b1;
          char_d  = itoa_pkg::CHAR_MINUS;
          last_d  = 1'b0;
          minus_d = 1'b0;
        end else if (!skip_q) begin
          ovld_d = 1'b1;
          char_d = nib_char;
          last_d = (rem_q == itoa_pkg::REM_W'(1));
          dig_d  = {dig_q[itoa_pkg::DIG_W-itoa_pkg::NIB_W-1:0], {itoa_pkg::NIB_W{1'b0}}};
          rem_d  = rem_q - itoa_pkg::REM_W'(1);
          if (rem_q == itoa_pkg::REM_W'(1)) begin
            busy_d = 1'b0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      minus_q <= 1'b0;
      skip_q  <= 1'b0;
      rem_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      minus_q <= minus_d;
      skip_q  <= skip_d;
      rem_q   <= rem_d;
      ovld_q  <= ovld_d;
    end
  end

  // digit shift register and output payload
  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o      = busy_q;
  assign out_valid_o = ovld_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== src/integer_to_ascii_formatter_core.sv =====
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | kind_i[1:0], value_i[31:0]
// out     | out_valid_o| out_stall_i | char_code_o[6:0], last_o
//
// decimal: shift-and-add-3, one bit a cycle, then the digits are handed over,
//   leading zero digits are dropped one at a time, the skip ends and the
//   digits are sent one by one; the minus goes out during the skip
// hex: no conversion, the same skip and send over 8 nibbles
// one number at a time: in_stall_o is high from acceptance until the cycle
//   after the last character has entered the output register
// a stalled output holds its character and delays the next one by the stalled
//   cycles; rst_ni clears all control state
module integer_to_ascii_formatter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [itoa_pkg::KIND_W-1:0]     kind_i,
  input  logic [itoa_pkg::VAL_W-1:0]      value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]     char_code_o,
  output logic                            last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic                        neg_q, neg_d;
  logic                        in_acc;
  logic                        in_neg;
  logic                        dab_start;
  logic [itoa_pkg::VAL_W-1:0]  mag;
  logic                        dab_done;
  logic [itoa_pkg::DIG_W-1:0]  bcd;
  logic                        emit_busy;
  itoa_pkg::load_t             ld;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_neg     = (kind_i == itoa_pkg::KIND_SDEC) && value_i[itoa_pkg::VAL_W-1];
  assign mag        = in_neg ? (~value_i + itoa_pkg::VAL_W'(1)) : value_i;
  assign dab_start  = in_acc && !kind_i[1];

  // sequencer: convert decimal or pass hex straight on, hand digits to the character stage
  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    ld.load   = 1'b0;
    ld.neg    = 1'b0;
    ld.hex    = 1'b0;
    ld.digits = bcd;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d = in_neg;
          if (kind_i[1]) begin
            ld.load   = 1'b1;
            ld.hex    = 1'b1;
            ld.digits = {value_i, {(itoa_pkg::DIG_W-itoa_pkg::VAL_W){1'b0}}};
            state_d   = ST_EMIT;
          end else begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          ld.load = 1'b1;
          ld.neg  = neg_q;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  itoa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .mag_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (bcd)
  );

  itoa_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ld),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

// ===== src/itoa_checker.sv =====
module itoa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [itoa_pkg::KIND_W-1:0]     kind_i,
  input logic [itoa_pkg::VAL_W-1:0]      value_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [itoa_pkg::CHAR_W-1:0]     char_code_o,
  input logic                            last_o
);

  // stalled output item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_code_o) && $stable(last_o))
    else $error("stalled output item changed");

  // one number at a time: input stalls right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // only digits, lower-case hex letters or minus appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o >= 7'h30 && char_code_o <= 7'h39) ||
                    (char_code_o >= 7'h61 && char_code_o <= 7'h66) ||
                    (char_code_o == itoa_pkg::CHAR_MINUS))
    else $error("illegal output character");

  // a minus sign never ends a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_code_o == itoa_pkg::CHAR_MINUS |-> !last_o)
    else $error("minus marked last");

endmodule

bind integer_to_ascii_formatter_core itoa_checker u_itoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .kind_i      (kind_i),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .char_code_o (char_code_o),
  .last_o      (last_o)
);

// ===== tb/integer_to_ascii_formatter_core_test.sv =====
module integer_to_ascii_formatter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // kind 3 is not in the package; only bit 1 is decoded, so it formats as hex
  localparam logic [itoa_pkg::KIND_W-1:0] KIND_HEX_ALT = 2'd3;
  localparam int unsigned DEC_BASE = 10;
  // cycles with no item moving on either side before the run is abandoned
  localparam int unsigned STUCK_LIMIT = 1000;
  // quiet cycles after the last character, covers a full decimal conversion
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_t;

  logic                        clk = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [itoa_pkg::KIND_W-1:0] kind = itoa_pkg::KIND_UDEC;
  logic [itoa_pkg::VAL_W-1:0]  value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [itoa_pkg::CHAR_W-1:0] char_code;
  logic                        last_char;

  char_t       expected_chars[$];
  char_t       want;
  int unsigned error_count = 0;
  int unsigned numbers_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned stuck_cycles = 0;
  int unsigned out_hold = 0;
  bit          steady = 1'b0;

  integer_to_ascii_formatter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .char_code_o (char_code),
    .last_o      (last_char)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // characters that print one number, queued in order
  function automatic void predict_chars(input logic [itoa_pkg::KIND_W-1:0] k,
                                        input logic [itoa_pkg::VAL_W-1:0] v);
    logic [itoa_pkg::VAL_W-1:0] mag;
    logic [itoa_pkg::NIB_W-1:0] nib;
    logic [itoa_pkg::NIB_W-1:0] dec_digits[$];
    char_t                      c;
    bit                         started;
    int                         p;
    started = 1'b0;
    if (k[1]) begin
      // hex, leading zero nibbles dropped but the lowest always printed
      for (p = itoa_pkg::HEX_DIGITS - 1; p >= 0; p--) begin
        nib = v[p*itoa_pkg::NIB_W +: itoa_pkg::NIB_W];
        if (nib != 0 || started || p == 0) begin
          started = 1'b1;
          c.code = (nib < DEC_BASE) ? itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(nib)
                                    : itoa_pkg::CHAR_A_OFS + itoa_pkg::CHAR_W'(nib);
          c.last = (p == 0);
          expected_chars.push_back(c);
        end
      end
    end else begin
      mag = v;
      // negative signed value: minus sign, then the magnitude mod 2^32
      if (k == itoa_pkg::KIND_SDEC && v[itoa_pkg::VAL_W-1]) begin
        mag = ~v + itoa_pkg::VAL_W'(1);
        c.code = itoa_pkg::CHAR_MINUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      do begin
        dec_digits.push_front(itoa_pkg::NIB_W'(mag % DEC_BASE));
        mag = mag / DEC_BASE;
      end while (mag != 0);
      for (p = 0; p < dec_digits.size(); p++) begin
        c.code = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(dec_digits[p]);
        c.last = (p == dec_digits.size() - 1);
        expected_chars.push_back(c);
      end
    end
  endfunction

  // random value spread over every digit count, near both ends of the range
  function automatic logic [itoa_pkg::VAL_W-1:0] random_value();
    unique case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 20);
      1:       return $urandom() >> $urandom_range(0, 31);
      2:       return ~($urandom() >> $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // present one item after a random gap and hold it until accepted
  task automatic send_number(input logic [itoa_pkg::KIND_W-1:0] k,
                             input logic [itoa_pkg::VAL_W-1:0] v);
    int unsigned gap;
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_chars.size() != 0) @(negedge clk);
  endtask

  // expectations are made as each item is taken
  always @(posedge clk) begin
    if (rst_ni && in_valid && !in_stall) begin
      predict_chars(kind, value);
      numbers_sent++;
    end
  end

  // compare each character taken against the oldest expectation
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", char_code, last_char));
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.code) begin
          report_mismatch($sformatf("char_code %h, wanted %h", char_code, want.code));
        end
        if (last_char !== want.last) begin
          report_mismatch($sformatf("last %b, wanted %b on char %h",
                                    last_char, want.last, want.code));
        end
      end
    end
  end

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else if (rst_ni && $urandom_range(0, 3) == 0) begin
      out_hold = pick_gap();
      out_stall <= (out_hold != 0);
      if (out_hold != 0) out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // field extremes, every kind and the named corner values
  task automatic test_directed();
    send_number(itoa_pkg::KIND_UDEC, 32'd0);
    send_number(itoa_pkg::KIND_UDEC, 32'd9);
    send_number(itoa_pkg::KIND_UDEC, 32'd10);
    send_number(itoa_pkg::KIND_UDEC, 32'd1234567890);
    send_number(itoa_pkg::KIND_UDEC, 32'hFFFF_FFFF);
    send_number(itoa_pkg::KIND_SDEC, 32'd0);
    send_number(itoa_pkg::KIND_SDEC, 32'd1);
    send_number(itoa_pkg::KIND_SDEC, 32'hFFFF_FFFF);
    send_number(itoa_pkg::KIND_SDEC, 32'h8000_0000);
    send_number(itoa_pkg::KIND_SDEC, 32'h7FFF_FFFF);
    send_number(itoa_pkg::KIND_SDEC, 32'hFFFF_FFF6);
    send_number(itoa_pkg::KIND_HEX, 32'd0);
    send_number(itoa_pkg::KIND_HEX, 32'h0000_000F);
    send_number(itoa_pkg::KIND_HEX, 32'h0000_0010);
    send_number(itoa_pkg::KIND_HEX, 32'hFFFF_FFFF);
    send_number(itoa_pkg::KIND_HEX, 32'h8000_0000);
    send_number(itoa_pkg::KIND_HEX, 32'hDEAD_BEEF);
    send_number(itoa_pkg::KIND_HEX, 32'h0ABC_DEF0);
    send_number(KIND_HEX_ALT, 32'd0);
    send_number(KIND_HEX_ALT, 32'h1234_5678);
    send_number(KIND_HEX_ALT, 32'hFFFF_FFFF);
    idle_input();
  endtask

  task automatic test_unsigned_decimal();
    repeat (50) send_number(itoa_pkg::KIND_UDEC, random_value());
    idle_input();
  endtask

  task automatic test_signed_decimal();
    repeat (50) send_number(itoa_pkg::KIND_SDEC, random_value());
    idle_input();
  endtask

  task automatic test_hex();
    repeat (50) begin
      send_number($urandom_range(0, 1) ? itoa_pkg::KIND_HEX : KIND_HEX_ALT, random_value());
    end
    idle_input();
  endtask

  // no idling on either side, kinds mixed
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (50) send_number(itoa_pkg::KIND_W'($urandom_range(0, 3)), random_value());
    idle_input();
    steady = 1'b0;
  endtask

  // sender holds off until the output has fully drained, now and then
  task automatic test_drain_pauses();
    int i;
    for (i = 0; i < 50; i++) begin
      send_number(itoa_pkg::KIND_W'($urandom_range(0, 3)), random_value());
      if (i % 10 == 9) begin
        idle_input();
        wait_drained();
      end
    end
    idle_input();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_ni <= 1'b1;

    test_directed();
    test_unsigned_decimal();
    test_signed_decimal();
    test_hex();
    test_back_to_back();
    test_drain_pauses();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d numbers as unsigned, signed and hex, %0d characters checked",
             numbers_sent, chars_checked);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d characters never seen", error_count,
               expected_chars.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/itoa_pkg.sv
src/itoa_dabble.sv
src/itoa_emit.sv
src/integer_to_ascii_formatter_core.sv
src/itoa_checker.sv
tb/integer_to_ascii_formatter_core_test.sv
